[rtl/core/wpc_pkg.sv]
// Shared constants, types and codes of the windowed point correspondence core.
package wpc_pkg;

  // Frame store geometry and window limit
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 15;

  // Field widths fixed by the word formats
  localparam int PIXEL_W   = 10;
  localparam int COORD_W   = 16;
  localparam int DIM_W     = 11;
  localparam int RADIUS_W  = 4;
  localparam int LIMIT_W   = 10;
  localparam int DIST_W    = 34;
  localparam int SQ_W      = 32;
  localparam int LIM_SQ_W  = 2 * LIMIT_W;
  localparam int POINT_W   = 3 * COORD_W;
  localparam int DIFF_W    = COORD_W + 1;

  // Store addressing
  localparam int ROW_IDX_W  = $clog2(MAX_HEIGHT);
  localparam int COL_IDX_W  = $clog2(MAX_WIDTH);
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  // Window coordinate width: holds any pixel, frame size or pixel plus radius
  localparam int SPAN_A = (ROW_IDX_W > COL_IDX_W) ? ROW_IDX_W : COL_IDX_W;
  localparam int SPAN_B = (PIXEL_W > DIM_W) ? PIXEL_W : DIM_W;
  localparam int POS_W  = ((SPAN_A > SPAN_B) ? SPAN_A : SPAN_B) + 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int REG_COUNT  = 6;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int PADDR_W    = $clog2(REG_COUNT * 4);
  localparam int APB_DATA_W = 32;

  // Register reset values
  localparam logic [DIM_W-1:0]          RST_IMAGE_WIDTH   = DIM_W'(640);
  localparam logic [DIM_W-1:0]          RST_IMAGE_HEIGHT  = DIM_W'(576);
  localparam logic signed [COORD_W-1:0] RST_DEPTH_MIN     = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_DEPTH_MAX     = 16'sd32767;
  localparam logic [RADIUS_W-1:0]       RST_WINDOW_RADIUS = RADIUS_W'(5);
  localparam logic [LIMIT_W-1:0]        RST_MATCH_LIMIT   = LIMIT_W'(5);

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_DEPTH_MIN     = 3'd2,
    REG_DEPTH_MAX     = 3'd3,
    REG_WINDOW_RADIUS = 3'd4,
    REG_MATCH_LIMIT   = 3'd5
  } reg_idx_t;

  // Classified operation for the back end
  typedef enum logic [1:0] {
    OP_STORE,
    OP_SEARCH,
    OP_MISS
  } op_t;

  // Live configuration
  typedef struct packed {
    logic [DIM_W-1:0]          image_width;
    logic [DIM_W-1:0]          image_height;
    logic signed [COORD_W-1:0] depth_min;
    logic signed [COORD_W-1:0] depth_max;
    logic [RADIUS_W-1:0]       window_radius;
    logic [LIMIT_W-1:0]        match_limit;
  } cfg_t;

  // One queued operation
  typedef struct packed {
    op_t                       op;
    logic [ROW_IDX_W-1:0]      row;
    logic [COL_IDX_W-1:0]      col;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [POS_W-1:0]          rlo;
    logic [POS_W-1:0]          rhi;
    logic [POS_W-1:0]          clo;
    logic [POS_W-1:0]          chi;
  } task_t;

endpackage

[rtl/core/wpc_if.sv]
// Handshake channels for input words and result words.
interface wpc_item_if import wpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [PIXEL_W-1:0]        pixel_row;
  logic [PIXEL_W-1:0]        pixel_col;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (output valid, cmd, pixel_row, pixel_col, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, cmd, pixel_row, pixel_col, point_x, point_y, point_z,
                output ready);
endinterface

interface wpc_result_if import wpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [PIXEL_W-1:0] match_row;
  logic [PIXEL_W-1:0] match_col;
  logic [DIST_W-1:0]  match_dist_sq;

  modport source (output valid, found, match_row, match_col, match_dist_sq,
                  input ready);
  modport sink (input valid, found, match_row, match_col, match_dist_sq,
                output ready);
endinterface

[rtl/core/windowed_point_correspondence_core.sv]
// Top level: configuration registers, front end, operation queue and back end.
//
//   channel   dir  handshake       word
//   items     in   valid/ready     cmd, pixel_row, pixel_col, point_x/y/z
//   results   out  valid/ready     found, match_row, match_col, match_dist_sq
//   apb       in   psel/penable    register write and read, pready tied high
//
// A write word goes into the frame store as it is popped. A query scans its clipped
// window at one point per cycle through the single-port frame store; a query with no
// window or a source depth out of band goes straight to its result without a scan.
// The front accepts words while the four-entry queue has room, also while a result
// waits to be taken. A finished result holds the back end until the result register
// frees. Reset restores the register defaults; the frame store is not cleared.
module windowed_point_correspondence_core import wpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  wpc_item_if.sink              items,
  wpc_result_if.source          results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     push, push_ready, pop, pop_valid;
  task_t    push_task, pop_task;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= RST_IMAGE_WIDTH;
      cfg.image_height  <= RST_IMAGE_HEIGHT;
      cfg.depth_min     <= RST_DEPTH_MIN;
      cfg.depth_max     <= RST_DEPTH_MAX;
      cfg.window_radius <= RST_WINDOW_RADIUS;
      cfg.match_limit   <= RST_MATCH_LIMIT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[DIM_W-1:0];
        REG_DEPTH_MIN:     cfg.depth_min     <= pwdata[COORD_W-1:0];
        REG_DEPTH_MAX:     cfg.depth_max     <= pwdata[COORD_W-1:0];
        REG_WINDOW_RADIUS: cfg.window_radius <= pwdata[RADIUS_W-1:0];
        REG_MATCH_LIMIT:   cfg.match_limit   <= pwdata[LIMIT_W-1:0];
        default:           ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(cfg.image_height);
      REG_DEPTH_MIN:     prdata = APB_DATA_W'($unsigned(cfg.depth_min));
      REG_DEPTH_MAX:     prdata = APB_DATA_W'($unsigned(cfg.depth_max));
      REG_WINDOW_RADIUS: prdata = APB_DATA_W'(cfg.window_radius);
      REG_MATCH_LIMIT:   prdata = APB_DATA_W'(cfg.match_limit);
      default:           prdata = '0;
    endcase
  end

  wpc_front u_front (
    .cfg        (cfg),
    .items      (items),
    .push       (push),
    .push_task  (push_task),
    .push_ready (push_ready)
  );

  wpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_task  (push_task),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_task   (pop_task),
    .pop        (pop)
  );

  wpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_task  (pop_task),
    .pop       (pop),
    .results   (results)
  );

endmodule

[rtl/core/wpc_front.sv]
// Front end: accepts input words, clips the search window and classifies them.
module wpc_front import wpc_pkg::*; (
  input  cfg_t          cfg,
  wpc_item_if.sink      items,
  output logic          push,
  output task_t         push_task,
  input  logic          push_ready
);

  logic [POS_W-1:0] w_raw, h_raw, w_lim, h_lim, rad_raw, rad;
  logic [POS_W-1:0] prow, pcol, rhi_a, chi_a;
  logic [POS_W-1:0] rlo, rhi, clo, chi;
  logic             in_band, in_store, window_empty, drop;

  // Frame size and radius saturation
  always_comb begin
    w_raw   = POS_W'(cfg.image_width);
    h_raw   = POS_W'(cfg.image_height);
    rad_raw = POS_W'(cfg.window_radius);
    if (w_raw == '0) begin
      w_lim = POS_W'(1);
    end else if (w_raw > POS_W'(MAX_WIDTH)) begin
      w_lim = POS_W'(MAX_WIDTH);
    end else begin
      w_lim = w_raw;
    end
    if (h_raw == '0) begin
      h_lim = POS_W'(1);
    end else if (h_raw > POS_W'(MAX_HEIGHT)) begin
      h_lim = POS_W'(MAX_HEIGHT);
    end else begin
      h_lim = h_raw;
    end
    rad = (rad_raw > POS_W'(MAX_RADIUS)) ? POS_W'(MAX_RADIUS) : rad_raw;
  end

  // Window bounds clipped to the frame
  always_comb begin
    prow  = POS_W'(items.pixel_row);
    pcol  = POS_W'(items.pixel_col);
    rhi_a = prow + rad;
    chi_a = pcol + rad;
    rlo   = (prow > rad) ? prow - rad : '0;
    clo   = (pcol > rad) ? pcol - rad : '0;
    rhi   = (rhi_a < h_lim - POS_W'(1)) ? rhi_a : h_lim - POS_W'(1);
    chi   = (chi_a < w_lim - POS_W'(1)) ? chi_a : w_lim - POS_W'(1);
    window_empty = (rlo > rhi) || (clo > chi);
  end

  // Classification
  always_comb begin
    in_band  = (items.point_z >= cfg.depth_min) && (items.point_z <= cfg.depth_max);
    in_store = (prow < POS_W'(MAX_HEIGHT)) && (pcol < POS_W'(MAX_WIDTH));
    drop     = (items.cmd == CMD_WRITE) && !in_store;

    push_task.row = prow[ROW_IDX_W-1:0];
    push_task.col = pcol[COL_IDX_W-1:0];
    push_task.x   = items.point_x;
    push_task.y   = items.point_y;
    push_task.z   = items.point_z;
    push_task.rlo = rlo;
    push_task.rhi = rhi;
    push_task.clo = clo;
    push_task.chi = chi;
    if (items.cmd == CMD_WRITE) begin
      push_task.op = OP_STORE;
    end else if (in_band && !window_empty) begin
      push_task.op = OP_SEARCH;
    end else begin
      push_task.op = OP_MISS;
    end
  end

  // Writes outside the store are taken and dropped here
  assign items.ready = push_ready;
  assign push        = items.valid && push_ready && !drop;

endmodule

[rtl/core/wpc_queue.sv]
// Short operation queue that decouples the front end from the back end.
module wpc_queue import wpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  task_t push_task,
  output logic  push_ready,
  output logic  pop_valid,
  output task_t pop_task,
  input  logic  pop
);

  task_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QCNT_W-1:0] count;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_task   = slots[head];

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_task;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/wpc_back.sv]
// Back end: frame store, window scan sequencer, distance pipeline and result word.
module wpc_back import wpc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          pop_valid,
  input  task_t         pop_task,
  output logic          pop,
  wpc_result_if.source  results
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state;

  // Frame store
  logic [POINT_W-1:0] mem [STORE_SIZE];
  logic [POINT_W-1:0] rd_data;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               mem_we, mem_re;

  // Current query and scan position
  logic signed [COORD_W-1:0] cur_x, cur_y, cur_z;
  logic [POS_W-1:0]          cur_rhi, cur_clo, cur_chi;
  logic [POS_W-1:0]          r, c;
  logic                      scan_last;

  // Pipeline stages
  logic                       rd_v, rd_last;
  logic [POS_W-1:0]           rd_r, rd_c;
  logic                       s1_v, s1_last, s1_ok;
  logic [POS_W-1:0]           s1_r, s1_c;
  logic [SQ_W-1:0]            s1_sq_x, s1_sq_y, s1_sq_z;
  logic                       s2_v, s2_last, s2_ok;
  logic [POS_W-1:0]           s2_r, s2_c;
  logic [DIST_W-1:0]          s2_sum;
  logic signed [COORD_W-1:0]  qx, qy, qz;
  logic signed [DIFF_W-1:0]   dx, dy, dz;
  logic signed [2*DIFF_W-1:0] px2, py2, pz2;

  // Running best
  logic                 have;
  logic [DIST_W-1:0]    best;
  logic [PIXEL_W-1:0]   brow, bcol;
  logic [LIM_SQ_W-1:0]  lim;
  logic                 hit;

  // Result word
  logic                 out_valid, out_found;
  logic [PIXEL_W-1:0]   out_row, out_col;
  logic [DIST_W-1:0]    out_dist;

  assign pop       = (state == ST_IDLE) && pop_valid;
  assign mem_we    = pop && (pop_task.op == OP_STORE);
  assign mem_re    = (state == ST_SCAN);
  assign scan_last = (r == cur_rhi) && (c == cur_chi);
  assign wr_addr   = ADDR_W'(pop_task.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pop_task.col);
  assign rd_addr   = ADDR_W'(r[ROW_IDX_W-1:0]) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'(c[COL_IDX_W-1:0]);

  // Single-port store: write on a store operation, registered read while scanning
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {pop_task.x, pop_task.y, pop_task.z};
    end else if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Squared differences of the fetched point
  always_comb begin
    qx  = rd_data[POINT_W-1 -: COORD_W];
    qy  = rd_data[2*COORD_W-1 -: COORD_W];
    qz  = rd_data[COORD_W-1:0];
    dx  = DIFF_W'(qx) - DIFF_W'(cur_x);
    dy  = DIFF_W'(qy) - DIFF_W'(cur_y);
    dz  = DIFF_W'(qz) - DIFF_W'(cur_z);
    px2 = dx * dx;
    py2 = dy * dy;
    pz2 = dz * dz;
  end

  // Distance pipeline payload
  always_ff @(posedge clk) begin
    rd_r    <= r;
    rd_c    <= c;
    rd_last <= scan_last;
    s1_r    <= rd_r;
    s1_c    <= rd_c;
    s1_last <= rd_last;
    s1_ok   <= (qz >= cfg.depth_min) && (qz <= cfg.depth_max);
    s1_sq_x <= px2[SQ_W-1:0];
    s1_sq_y <= py2[SQ_W-1:0];
    s1_sq_z <= pz2[SQ_W-1:0];
    s2_r    <= s1_r;
    s2_c    <= s1_c;
    s2_last <= s1_last;
    s2_ok   <= s1_ok;
    s2_sum  <= DIST_W'(s1_sq_x) + DIST_W'(s1_sq_y) + DIST_W'(s1_sq_z);
  end

  // Distance pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      rd_v <= mem_re;
      s1_v <= rd_v;
      s2_v <= s1_v;
    end
  end

  // Acceptance test on the final best
  assign lim = LIM_SQ_W'(cfg.match_limit) * LIM_SQ_W'(cfg.match_limit);
  assign hit = have && (best <= DIST_W'(lim));

  // Sequencer, running best and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      have      <= 1'b0;
    end else begin
      // Result register frees when taken; a new word is loaded below instead
      if (results.ready && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end

      // Keep the least distance; strict compare keeps the earlier point on ties
      if ((state != ST_IDLE) && s2_v && s2_ok && (!have || (s2_sum < best))) begin
        have <= 1'b1;
        best <= s2_sum;
        brow <= PIXEL_W'(s2_r);
        bcol <= PIXEL_W'(s2_c);
      end

      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            case (pop_task.op)
              OP_SEARCH: begin
                cur_x   <= pop_task.x;
                cur_y   <= pop_task.y;
                cur_z   <= pop_task.z;
                cur_rhi <= pop_task.rhi;
                cur_clo <= pop_task.clo;
                cur_chi <= pop_task.chi;
                r       <= pop_task.rlo;
                c       <= pop_task.clo;
                have    <= 1'b0;
                state   <= ST_SCAN;
              end
              OP_MISS: begin
                have  <= 1'b0;
                state <= ST_RESULT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_DRAIN;
          end else if (c == cur_chi) begin
            c <= cur_clo;
            r <= r + POS_W'(1);
          end else begin
            c <= c + POS_W'(1);
          end
        end
        ST_DRAIN: begin
          if (s2_v && s2_last) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_found <= hit;
            out_row   <= hit ? brow : '0;
            out_col   <= hit ? bcol : '0;
            out_dist  <= hit ? best : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid         = out_valid;
  assign results.found         = out_found;
  assign results.match_row     = out_row;
  assign results.match_col     = out_col;
  assign results.match_dist_sq = out_dist;

endmodule

[tb/sv/tb_windowed_point_correspondence_core.sv]
// Self-checking regression of the windowed point correspondence core.
module tb_windowed_point_correspondence_core;
  import wpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    shortint x;
    shortint y;
    shortint z;
  } point_t;

  typedef struct {
    logic               cmd;
    logic [PIXEL_W-1:0] row;
    logic [PIXEL_W-1:0] col;
    point_t             pt;
  } word_t;

  typedef struct packed {
    logic               found;
    logic [PIXEL_W-1:0] row;
    logic [PIXEL_W-1:0] col;
    logic [DIST_W-1:0]  dsq;
  } result_t;

  // Mirror of the frame store and registers; predicts one match per query word
  class match_scoreboard;
    point_t              cloud[int];
    logic [DIM_W-1:0]    cols_reg;
    logic [DIM_W-1:0]    rows_reg;
    shortint             zmin;
    shortint             zmax;
    logic [RADIUS_W-1:0] radius_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    result_t             pending_matches[$];
    int                  errors;

    function new();
      cols_reg   = RST_IMAGE_WIDTH;
      rows_reg   = RST_IMAGE_HEIGHT;
      zmin       = RST_DEPTH_MIN;
      zmax       = RST_DEPTH_MAX;
      radius_reg = RST_WINDOW_RADIUS;
      limit_reg  = RST_MATCH_LIMIT;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:   cols_reg   = value[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  rows_reg   = value[DIM_W-1:0];
        REG_DEPTH_MIN:     zmin       = value[COORD_W-1:0];
        REG_DEPTH_MAX:     zmax       = value[COORD_W-1:0];
        REG_WINDOW_RADIUS: radius_reg = value[RADIUS_W-1:0];
        REG_MATCH_LIMIT:   limit_reg  = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // frame size saturates to [1, MAX]
    function int frame_cols();
      return (cols_reg == 0) ? 1 : ((cols_reg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_reg));
    endfunction

    function int frame_rows();
      return (rows_reg == 0) ? 1 : ((rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_reg));
    endfunction

    // search window clipped to the frame; empty when lo > hi
    function void window_of(int row, int col, output int rlo, output int rhi,
                            output int clo, output int chi);
      int rad;
      rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
      rlo = (row > rad) ? row - rad : 0;
      rhi = (row + rad < frame_rows() - 1) ? row + rad : frame_rows() - 1;
      clo = (col > rad) ? col - rad : 0;
      chi = (col + rad < frame_cols() - 1) ? col + rad : frame_cols() - 1;
    endfunction

    function bit in_band(shortint z);
      return (z >= zmin) && (z <= zmax);
    endfunction

    function longint gap_sq(shortint a, shortint b);
      longint g;
      g = longint'(a) - longint'(b);
      return g * g;
    endfunction

    // accepted input word: store a point or predict the match of a query
    function void note_word(word_t w);
      int      rlo, rhi, clo, chi, addr;
      bit      have;
      longint  best, d;
      point_t  q;
      result_t res;
      if (w.cmd == CMD_WRITE) begin
        cloud[int'(w.row) * MAX_WIDTH + int'(w.col)] = w.pt;
        return;
      end
      have = 0;
      best = 0;
      res  = '0;
      if (in_band(w.pt.z)) begin
        window_of(int'(w.row), int'(w.col), rlo, rhi, clo, chi);
        for (int r = rlo; r <= rhi; r++) begin
          for (int c = clo; c <= chi; c++) begin
            addr = r * MAX_WIDTH + c;
            q = cloud.exists(addr) ? cloud[addr] : point_t'{0, 0, 0};
            if (!in_band(q.z)) continue;
            d = gap_sq(q.x, w.pt.x) + gap_sq(q.y, w.pt.y) + gap_sq(q.z, w.pt.z);
            // strict compare keeps the first point in row-major order on ties
            if (!have || d < best) begin
              have    = 1;
              best    = d;
              res.row = PIXEL_W'(r);
              res.col = PIXEL_W'(c);
            end
          end
        end
      end
      if (have && best <= longint'(limit_reg) * longint'(limit_reg)) begin
        res.found = 1'b1;
        res.dsq   = best[DIST_W-1:0];
      end else begin
        res = '0;
      end
      pending_matches = {pending_matches, res};
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // accepted result word against the oldest predicted match
    task check_match(result_t got);
      result_t want;
      if (pending_matches.size() == 0) begin
        report($sformatf("result with none expected: found=%0d row=%0d col=%0d dsq=%0d",
                         got.found, got.row, got.col, got.dsq));
        return;
      end
      want = pending_matches.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0d, expected %0d", got.found, want.found));
      if (got.row !== want.row)
        report($sformatf("match_row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("match_col %0d, expected %0d", got.col, want.col));
      if (got.dsq !== want.dsq)
        report($sformatf("match_dist_sq %0d, expected %0d", got.dsq, want.dsq));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  wpc_item_if   items_ch();
  wpc_result_if results_ch();

  windowed_point_correspondence_core DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  match_scoreboard sb;
  idle_mode_t      idle_mode;
  bit              hold_request;
  bit              primed[int];
  int              scene_step, scene_x0, scene_y0, scene_z0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && items_ch.valid && items_ch.ready)
      sb.note_word('{items_ch.cmd, items_ch.pixel_row, items_ch.pixel_col,
                     '{items_ch.point_x, items_ch.point_y, items_ch.point_z}});
    if (!rst && results_ch.valid && results_ch.ready)
      sb.check_match(result_t'({results_ch.found, results_ch.match_row,
                                results_ch.match_col, results_ch.match_dist_sq}));
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 66;
      IDLE_BOTH:   return $urandom_range(99) < 38;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 66;
      IDLE_BOTH:     return $urandom_range(99) < 38;
      default:       return 1'b0;
    endcase
  endfunction

  // Result ready: random stalls, plus a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= !receiver_gap();
      end
    end
  end

  function automatic point_t pt(int x, int y, int z);
    point_t p;
    p.x = shortint'(x);
    p.y = shortint'(y);
    p.z = shortint'(z);
    return p;
  endfunction

  function automatic word_t make_word(logic cmd, int row, int col, point_t p);
    word_t w;
    w.cmd = cmd;
    w.row = row[PIXEL_W-1:0];
    w.col = col[PIXEL_W-1:0];
    w.pt  = p;
    return w;
  endfunction

  function automatic point_t random_point();
    return pt($urandom(), $urandom(), $urandom());
  endfunction

  function automatic int clamp_pixel(int v);
    return (v < 0) ? 0 : ((v > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : v);
  endfunction

  // planar scene with one millimetre of jitter per axis
  function automatic point_t scene_at(int r, int c);
    return pt(scene_x0 + c * scene_step + int'($urandom_range(2)) - 1,
              scene_y0 + r * scene_step + int'($urandom_range(2)) - 1,
              scene_z0 + int'($urandom_range(2)) - 1);
  endfunction

  // a depth the current band rejects (any depth when the band is full)
  function automatic shortint outside_band();
    bit lower_ok, upper_ok;
    lower_ok = sb.zmin > -32768;
    upper_ok = sb.zmax < 32767;
    if (lower_ok && (!upper_ok || $urandom_range(1)))
      return shortint'(int'($urandom_range(int'(sb.zmin) + 32767)) - 32768);
    if (upper_ok)
      return shortint'(int'(sb.zmax) + 1 + int'($urandom_range(32766 - int'(sb.zmax))));
    return shortint'($urandom());
  endfunction

  // Offer one input word, with random gaps, until it is taken
  task automatic send_word(word_t w);
    @(negedge clk);
    while (sender_gap()) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid     <= 1'b1;
    items_ch.cmd       <= w.cmd;
    items_ch.pixel_row <= w.row;
    items_ch.pixel_col <= w.col;
    items_ch.point_x   <= w.pt.x;
    items_ch.point_y   <= w.pt.y;
    items_ch.point_z   <= w.pt.z;
    if (w.cmd == CMD_WRITE) primed[int'(w.row) * MAX_WIDTH + int'(w.col)] = 1'b1;
    do @(posedge clk); while (!items_ch.ready);
  endtask

  // Fill every never-written pixel of the query window, then send the query
  task automatic send_query(word_t q);
    int rlo, rhi, clo, chi;
    sb.window_of(int'(q.row), int'(q.col), rlo, rhi, clo, chi);
    for (int r = rlo; r <= rhi; r++)
      for (int c = clo; c <= chi; c++)
        if (!primed.exists(r * MAX_WIDTH + c))
          send_word(make_word(CMD_WRITE, r, c, scene_at(r, c)));
    send_word(q);
  endtask

  task automatic end_burst();
    @(negedge clk);
    items_ch.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, APB_DATA_W'(value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int cols, int rows, int zlo, int zhi, int radius, int limit);
    write_reg(REG_IMAGE_WIDTH, cols);
    write_reg(REG_IMAGE_HEIGHT, rows);
    write_reg(REG_DEPTH_MIN, zlo);
    write_reg(REG_DEPTH_MAX, zhi);
    write_reg(REG_WINDOW_RADIUS, radius);
    write_reg(REG_MATCH_LIMIT, limit);
  endtask

  // Random words, mostly around the frame corners and center and scene-consistent
  task automatic run_phase(int count, idle_mode_t mode, bit squeeze);
    int     pick, r, c, w, h, spread;
    point_t p;
    idle_mode  = mode;
    scene_step = int'($urandom_range(3)) + 1;
    scene_x0   = int'($urandom_range(65535)) - 32768;
    scene_y0   = int'($urandom_range(65535)) - 32768;
    scene_z0   = (sb.zmin <= sb.zmax) ? (int'(sb.zmin) + int'(sb.zmax)) / 2
                                      : int'($urandom_range(65535)) - 32768;
    w = sb.frame_cols();
    h = sb.frame_rows();
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 3) hold_request = 1'b1;
      case ($urandom_range(4))
        0:       begin r = 0;     c = 0;     end
        1:       begin r = 0;     c = w - 1; end
        2:       begin r = h - 1; c = 0;     end
        3:       begin r = h - 1; c = w - 1; end
        default: begin r = h / 2; c = w / 2; end
      endcase
      r = clamp_pixel(r + int'($urandom_range(6)) - 3);
      c = clamp_pixel(c + int'($urandom_range(6)) - 3);
      p = scene_at(r, c);
      pick = $urandom_range(99);
      if (pick < 55) begin
        // source near the scene: small offsets, now and then a wider one
        spread = ($urandom_range(9) == 0) ? 40 : 3;
        p.x += shortint'(int'($urandom_range(2 * spread)) - spread);
        p.y += shortint'(int'($urandom_range(2 * spread)) - spread);
        p.z += shortint'(int'($urandom_range(2 * spread)) - spread);
        send_query(make_word(CMD_QUERY, r, c, p));
      end else if (pick < 70) begin
        if ($urandom_range(4) == 0) p.z = outside_band();
        send_word(make_word(CMD_WRITE, r, c, p));
      end else if (pick < 80) begin
        send_word(make_word(CMD_WRITE, $urandom_range(1023), $urandom_range(1023),
                            random_point()));
      end else if (pick < 90) begin
        if ($urandom_range(1)) begin
          r = $urandom_range(1023);
          c = $urandom_range(1023);
        end
        send_query(make_word(CMD_QUERY, r, c, random_point()));
      end else begin
        p.z = outside_band();
        send_query(make_word(CMD_QUERY, r, c, p));
      end
    end
    end_burst();
    wait_quiet();
  endtask

  initial begin
    sb                 = new();
    idle_mode          = IDLE_NONE;
    hold_request       = 1'b0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    items_ch.valid     = 1'b0;
    items_ch.cmd       = CMD_WRITE;
    items_ch.pixel_row = '0;
    items_ch.pixel_col = '0;
    items_ch.point_x   = '0;
    items_ch.point_y   = '0;
    items_ch.point_z   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: 4x3 frame, band [-1000, 30000], radius 1, widest limit
    configure(4, 3, -1000, 30000, 1, 1023);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        if (r == 2 && c == 3)
          send_word(make_word(CMD_WRITE, r, c, pt(-32768, 32767, 30000)));
        else if (r == 0 && c == 3)
          send_word(make_word(CMD_WRITE, r, c, pt(300, 0, 30001)));
        else if (r == 1 && c == 0)
          send_word(make_word(CMD_WRITE, r, c, pt(0, 100, -1000)));
        else
          send_word(make_word(CMD_WRITE, r, c, pt(100 * c, 100 * r, 1000)));
    // distance exactly at the limit, then one past it
    send_word(make_word(CMD_QUERY, 0, 0, pt(-1023, 0, 1000)));
    send_word(make_word(CMD_QUERY, 0, 0, pt(-1023, -1, 1000)));
    // equal distances: the earlier pixel wins
    send_word(make_word(CMD_QUERY, 1, 1, pt(150, 100, 1000)));
    // extreme coordinates, exact hit and far miss
    send_word(make_word(CMD_QUERY, 2, 3, pt(-32768, 32767, 30000)));
    send_word(make_word(CMD_QUERY, 2, 3, pt(32767, -32768, 30000)));
    // source depth just outside the band on either side
    send_word(make_word(CMD_QUERY, 0, 3, pt(300, 0, 30001)));
    send_word(make_word(CMD_QUERY, 0, 3, pt(300, 0, -1001)));
    // own pixel out of band, tie between two of its neighbors
    send_word(make_word(CMD_QUERY, 0, 3, pt(300, 0, 1000)));
    // destination depth on the lower band edge
    send_word(make_word(CMD_QUERY, 1, 0, pt(0, 100, -1000)));
    // query far outside the frame: empty window
    send_word(make_word(CMD_QUERY, 1023, 1023, pt(0, 0, 1000)));
    // query just outside the frame: clipped window
    send_word(make_word(CMD_QUERY, 3, 1, pt(100, 200, 1000)));
    send_word(make_word(CMD_QUERY, 2, 4, pt(300, 200, 1000)));
    end_burst();
    wait_quiet();

    // Random phases over a spread of settings
    configure(16, 12, -32768, 32767, 2, 6);
    run_phase(200, IDLE_NONE, 1'b1);
    configure(0, 40, 0, 5000, 3, 4);
    run_phase(100, IDLE_SENDER, 1'b0);
    configure(2047, 1024, 100, 4000, 1, 10);
    run_phase(80, IDLE_RECEIVER, 1'b0);
    configure(30, 0, 500, -500, 4, 1023);
    run_phase(60, IDLE_BOTH, 1'b0);
    configure(12, 10, -32768, 32767, 15, 1023);
    run_phase(40, IDLE_BOTH, 1'b0);
    configure(64, 20, -2000, 2000, 0, 0);
    run_phase(120, IDLE_RECEIVER, 1'b0);
    configure(16, 12, -32768, -100, 5, 1023);
    run_phase(100, IDLE_SENDER, 1'b0);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("windowed_point_correspondence_core regression: pass");
    end else begin
      $display("windowed_point_correspondence_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("windowed_point_correspondence_core regression: fail");
    $finish;
  end

endmodule

[windowed_point_correspondence_core.f]
rtl/core/wpc_pkg.sv
rtl/core/wpc_if.sv
rtl/core/wpc_front.sv
rtl/core/wpc_queue.sv
rtl/core/wpc_back.sv
rtl/core/windowed_point_correspondence_core.sv
tb/sv/tb_windowed_point_correspondence_core.sv
